[src/sorted_point_set_row_major_defines.svh]
// Assertion macros for the sorted point set.
// Used by sorted_point_set_row_major; expects clk and rst_n in scope.
`ifndef SORTED_POINT_SET_ROW_MAJOR_DEFINES_SVH
`define SORTED_POINT_SET_ROW_MAJOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sps_pkg.sv]
// Shared types and codes for the sorted point set.
// No dependencies; imported by sorted_point_set_row_major.
package sps_pkg;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;  // duplicate or not found
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_DEC,
    ST_SHRD,
    ST_SHWR,
    ST_PUT,
    ST_OUT
  } state_t;

endpackage

[src/sorted_point_set_row_major.sv]
// Sorted point set: ordered table of (x, y, tag) with insert and remove.
// One table memory, a linear search and a shift sequencer.
// Depends on sps_pkg and sorted_point_set_row_major_defines.svh.
//
// Usage:
//   in_*  beats carry one operation: tuser selects insert (0) or remove (1),
//         tdata carries key_x, key_y and tag. Only one item is in flight;
//         in_tready is high only while the block is idle.
//   out_* beats carry one result per item: tuser is the status, tdata holds
//         the sorted position and the entry count after the operation.
//   Sequence: the search reads each entry ahead of the key (registered
//   read, then compare) until it ends, the block decides, each entry to
//   move is read, then written, the new entry is stored on an insert, and
//   the result is presented. The registered read of the table memory sets
//   the pace of the search and of the shift.
//   The result stays on out_* until out_tready; the next item is taken after.
//   Reset clears the entry count and the sequencer; the table memory itself
//   is not cleared, since only entries below the count are ever read.
`include "sorted_point_set_row_major_defines.svh"

module sorted_point_set_row_major
  import sps_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // key_x[7:0], key_y[15:8], tag[23:16]
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // position[5:0], count[12:6], zero pad
  output logic [1:0]  out_tuser   // status
);

  localparam int KW = (COORD_BITS < 8) ? COORD_BITS : 8;
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = 2 * KW + 8;

  state_t state_r, state_nxt;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data_r;

  logic          op_r;
  logic [KW-1:0] x_r, y_r;
  logic [7:0]    tag_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] sh_r, sh_nxt;
  logic          hit_r, hit_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [IW-1:0] pos_r, pos_nxt;

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  logic [2*KW-1:0] key, rd_key;
  logic            key_lt, key_eq;
  logic            at_end, full, empty_tail;
  logic [CW-1:0]   sh_m1, sh_p1;
  logic [CW:0]     sh_p2, idx_p1;
  logic            ins_more, rem_more, rem_start;
  logic            accept_in;

  assign accept_in = in_tvalid && in_tready;

  assign key    = {y_r, x_r};
  assign rd_key = rd_data_r[2*KW-1:0];
  assign key_lt = rd_key < key;
  assign key_eq = rd_key == key;

  assign at_end     = idx_r == count_r;
  assign full       = count_r == CW'(CAPACITY);
  assign empty_tail = count_r == idx_r;

  assign sh_m1     = sh_r - CW'(1);
  assign sh_p1     = sh_r + CW'(1);
  assign sh_p2     = {1'b0, sh_r} + (CW+1)'(2);
  assign idx_p1    = {1'b0, idx_r} + (CW+1)'(1);
  assign ins_more  = sh_m1 != idx_r;
  assign rem_more  = sh_p2 < {1'b0, count_r};
  assign rem_start = idx_p1 < {1'b0, count_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept_in) state_nxt = ST_RD;
      ST_RD:   state_nxt = at_end ? ST_DEC : ST_CMP;
      ST_CMP:  state_nxt = key_lt ? ST_RD : ST_DEC;
      ST_DEC: begin
        if (op_r == FUNC_INSERT) begin
          priority if (hit_r || full) state_nxt = ST_OUT;
          else if (empty_tail)        state_nxt = ST_PUT;
          else                        state_nxt = ST_SHRD;
        end else begin
          priority if (!hit_r)  state_nxt = ST_OUT;
          else if (rem_start)   state_nxt = ST_SHRD;
          else                  state_nxt = ST_OUT;
        end
      end
      ST_SHRD: state_nxt = ST_SHWR;
      ST_SHWR: begin
        if (op_r == FUNC_INSERT) state_nxt = ins_more ? ST_SHRD : ST_PUT;
        else                     state_nxt = rem_more ? ST_SHRD : ST_OUT;
      end
      ST_PUT:  state_nxt = ST_OUT;
      ST_OUT:  if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    sh_nxt     = sh_r;
    hit_nxt    = hit_r;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    rd_en      = 1'b0;
    rd_addr    = idx_r[IW-1:0];
    wr_en      = 1'b0;
    wr_addr    = sh_r[IW-1:0];
    wr_data    = rd_data_r;
    unique case (state_r)
      ST_IDLE: idx_nxt = '0;
      ST_RD: begin
        rd_en = !at_end;
        if (at_end) hit_nxt = 1'b0;
      end
      ST_CMP: begin
        if (key_lt) idx_nxt = idx_r + CW'(1);
        else        hit_nxt = key_eq;
      end
      ST_DEC: begin
        status_nxt = STATUS_DONE;
        pos_nxt    = idx_r[IW-1:0];
        if (op_r == FUNC_INSERT) begin
          sh_nxt = count_r;
          priority if (hit_r) begin
            status_nxt = STATUS_MISS;
            pos_nxt    = '0;
          end else if (full) begin
            status_nxt = STATUS_FULL;
            pos_nxt    = '0;
          end
        end else begin
          sh_nxt = idx_r;
          if (!hit_r) begin
            status_nxt = STATUS_MISS;
            pos_nxt    = '0;
          end else if (!rem_start) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      ST_SHRD: begin
        rd_en   = 1'b1;
        rd_addr = (op_r == FUNC_INSERT) ? sh_m1[IW-1:0] : sh_p1[IW-1:0];
      end
      ST_SHWR: begin
        wr_en  = 1'b1;
        sh_nxt = (op_r == FUNC_INSERT) ? sh_m1 : sh_p1;
        // remove finishes here once the tail has moved up
        if (op_r == FUNC_REMOVE && !rem_more) count_nxt = count_r - CW'(1);
      end
      ST_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r[IW-1:0];
        wr_data   = {tag_r, y_r, x_r};
        count_nxt = count_r + CW'(1);
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      op_r  <= in_tuser;
      x_r   <= in_tdata[KW-1:0];
      y_r   <= in_tdata[8 +: KW];
      tag_r <= in_tdata[23:16];
    end
    idx_r    <= idx_nxt;
    sh_r     <= sh_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
  end

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = state_r == ST_OUT;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, 7'(count_r), 6'(pos_r)};

  `SPS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(CAPACITY),
    "entry count exceeds capacity")
  `SPS_ASSERT_NOW(a_full_status, out_tvalid && status_r == STATUS_FULL,
    count_r == CW'(CAPACITY), "table-full status with free space")
  `SPS_ASSERT_NEXT(a_busy_after_accept, accept_in, !in_tready,
    "ready while an item is in flight")
  `SPS_ASSERT_NEXT(a_count_step, state_r != ST_IDLE,
    count_r == $past(count_r) || count_r == $past(count_r) + CW'(1) ||
    count_r == $past(count_r) - CW'(1), "count moved by more than one")

endmodule

[verif/tb_sorted_point_set_row_major.sv]
// Self-checking testbench for sorted_point_set_row_major: streams insert and remove beats,
// predicts status, position and count from a shadow table, and compares every result beat.
// Depends on sps_pkg and the sorted_point_set_row_major RTL.
module tb_sorted_point_set_row_major;
  import sps_pkg::*;

  localparam int CAPACITY   = 64;
  localparam int COORD_BITS = 8;
  localparam logic [7:0] COORD_MASK = 8'((1 << COORD_BITS) - 1);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 64;

  typedef struct packed {
    logic       func;
    logic [7:0] kx;
    logic [7:0] ky;
    logic [7:0] tg;
  } table_op_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] tag;
  } point_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] position;
    logic [6:0] count;
  } op_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // key_x[7:0], key_y[15:8], tag[23:16]
  logic        in_tuser = 1'b0; // func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // position[5:0], count[12:6], zero pad
  logic [1:0]  out_tuser;       // status

  table_op_t  pending_ops[$];
  op_result_t expected_results[$];

  // shadow copy of the sorted table
  point_t held[CAPACITY];
  int     n_held = 0;

  int unsigned err_count = 0;
  int unsigned ops_taken = 0;
  int unsigned cycle_count = 0;

  int burst_left = 0;
  int gap_left = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  int rx_mode = 0;
  int rx_phase = 0;

  sorted_point_set_row_major #(
    .CAPACITY  (CAPACITY),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic op_result_t apply_table_op(table_op_t op);
    op_result_t r;
    logic [15:0] k;
    int p;
    int i;
    bit hit;
    k = {op.ky & COORD_MASK, op.kx & COORD_MASK};
    p = 0;
    while (p < n_held && {held[p].y, held[p].x} < k) p++;
    hit = (p < n_held) && ({held[p].y, held[p].x} == k);
    r.status = STATUS_DONE;
    r.position = '0;
    if (op.func == FUNC_INSERT) begin
      if (hit) begin
        r.status = STATUS_MISS;
      end else if (n_held >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        for (i = n_held; i > p; i--) held[i] = held[i - 1];
        held[p] = '{x: op.kx & COORD_MASK, y: op.ky & COORD_MASK, tag: op.tg};
        n_held++;
        r.position = 6'(p);
      end
    end else if (!hit) begin
      r.status = STATUS_MISS;
    end else begin
      for (i = p; i + 1 < n_held; i++) held[i] = held[i + 1];
      n_held--;
      r.position = 6'(p);
    end
    r.count = 7'(n_held);
    return r;
  endfunction

  task automatic add_op(logic func, logic [7:0] kx, logic [7:0] ky, logic [7:0] tg);
    pending_ops.push_back('{func: func, kx: kx, ky: ky, tg: tg});
  endtask

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    if (err_count < 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    err_count++;
  endtask

  // sender: bursts of beats with random gaps
  always @(posedge clk) begin : sender
    table_op_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_table_op({in_tuser, in_tdata[7:0], in_tdata[15:8],
                                                   in_tdata[23:16]}));
        ops_taken <= ops_taken + 1;
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered beat
      end else if (gap_left != 0) begin
        in_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() != 0) begin
        nxt = pending_ops.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.func;
        in_tdata <= {nxt.tg, nxt.ky, nxt.kx};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off once, midway through the run
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && ops_taken >= 600) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // receiver: stall pattern switches to a random mode each time rx_phase wraps
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_mode <= 0;
      rx_phase <= 0;
    end else begin
      if (rx_phase == 49) begin
        rx_phase <= 0;
        rx_mode <= $urandom_range(0, 2);
      end else begin
        rx_phase <= rx_phase + 1;
      end
      if (hold_left != 0) out_tready <= 1'b0;
      else if (rx_mode == 0) out_tready <= 1'b1;
      else if (rx_mode == 1) out_tready <= $urandom_range(0, 1);
      else out_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin : monitor
    op_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result beat, status", 0, out_tuser);
      end else begin
        want = expected_results.pop_front();
        if (out_tuser != want.status) flag_mismatch("status", want.status, out_tuser);
        if (out_tdata[5:0] != want.position)
          flag_mismatch("position", want.position, out_tdata[5:0]);
        if (out_tdata[12:6] != want.count) flag_mismatch("count", want.count, out_tdata[12:6]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] xmask;
    logic [7:0] ymask;
    logic [7:0] kx;
    logic [7:0] ky;
    logic       func;
    int r;
    int n;
    int unsigned total_ops;

    // directed: empty table, extremes, ordering, duplicates, misses
    add_op(FUNC_REMOVE, 8'd5, 8'd5, 8'd0);
    add_op(FUNC_INSERT, 8'd10, 8'd10, 8'hFF);
    add_op(FUNC_INSERT, 8'd0, 8'd0, 8'h00);
    add_op(FUNC_INSERT, 8'd255, 8'd255, 8'hA5);
    add_op(FUNC_INSERT, 8'd255, 8'd0, 8'h5A);
    add_op(FUNC_INSERT, 8'd0, 8'd255, 8'h01);
    add_op(FUNC_INSERT, 8'd11, 8'd10, 8'h80);
    add_op(FUNC_INSERT, 8'd9, 8'd10, 8'h7F);
    add_op(FUNC_INSERT, 8'd10, 8'd10, 8'h33);
    add_op(FUNC_INSERT, 8'h55, 8'hAA, 8'h55);
    add_op(FUNC_INSERT, 8'hAA, 8'h55, 8'hAA);
    add_op(FUNC_REMOVE, 8'd1, 8'd1, 8'hFF);
    add_op(FUNC_REMOVE, 8'd0, 8'd0, 8'h00);
    add_op(FUNC_REMOVE, 8'd255, 8'd255, 8'h00);
    add_op(FUNC_REMOVE, 8'd255, 8'd255, 8'h00);
    add_op(FUNC_REMOVE, 8'd10, 8'd10, 8'h00);
    add_op(FUNC_REMOVE, 8'd255, 8'd0, 8'h00);
    add_op(FUNC_REMOVE, 8'd0, 8'd255, 8'h00);
    add_op(FUNC_REMOVE, 8'd11, 8'd10, 8'h00);
    add_op(FUNC_REMOVE, 8'd9, 8'd10, 8'h00);
    add_op(FUNC_REMOVE, 8'h55, 8'hAA, 8'h00);
    add_op(FUNC_REMOVE, 8'hAA, 8'h55, 8'h00);
    add_op(FUNC_REMOVE, 8'hAA, 8'h55, 8'h00);

    // random rounds: an insert-heavy fill past capacity, then a remove-heavy drain;
    // most keys come from a 128-key pool so hits, duplicates and full refusals are common
    for (r = 0; r < 6; r++) begin
      xmask = $urandom_range(0, 255);
      ymask = $urandom_range(0, 255);
      for (n = 0; n < 200; n++) begin
        if (n < 100) func = ($urandom_range(0, 9) == 0) ? FUNC_REMOVE : FUNC_INSERT;
        else func = ($urandom_range(0, 19) < 17) ? FUNC_REMOVE : FUNC_INSERT;
        if ($urandom_range(0, 9) == 0) begin
          kx = $urandom_range(0, 255);
          ky = $urandom_range(0, 255);
        end else begin
          kx = 8'($urandom_range(0, 15)) ^ xmask;
          ky = 8'($urandom_range(0, 7)) ^ ymask;
        end
        add_op(func, kx, ky, 8'($urandom_range(0, 255)));
      end
    end
    total_ops = pending_ops.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // wait until every beat is accepted and every result has come back
    while (ops_taken < total_ops || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
